[rtl/trq_pkg.sv]
// Package for the two-class ready queue: item types, cell link types,
// operation and status codes. No dependencies; used by every RTL file.
`default_nettype none

package trq_pkg;

  localparam int TASK_ID_W         = 6;
  localparam int PRIO_W            = 8;
  localparam int CNT_W             = 7;
  localparam int MAX_CELLS         = 64;
  localparam int NUM_TASKS_DEFAULT = 64;

  localparam logic [1:0] MODE_AWAKEN = 2'd0;
  localparam logic [1:0] MODE_PICK   = 2'd1;
  localparam logic [1:0] MODE_REPRIO = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [1:0] ST_DONE           = 2'd0;
  localparam logic [1:0] ST_NOT_QUEUED     = 2'd1;
  localparam logic [1:0] ST_ALREADY_QUEUED = 2'd2;

  localparam logic [PRIO_W-1:0] LOW_PRIORITY_VALUE = 8'd1;

  // Class bit: 1 is the low class, 0 the high class.
  localparam logic CLS_HIGH = 1'b0;
  localparam logic CLS_LOW  = 1'b1;

  typedef struct packed {
    logic [1:0]           mode;
    logic [TASK_ID_W-1:0] task_id;
    logic [PRIO_W-1:0]    priority_req;
  } req_t;

  typedef struct packed {
    logic                 picked_valid;
    logic [TASK_ID_W-1:0] picked_id;
    logic                 any_ready;
    logic [1:0]           status;
  } res_t;

  typedef struct packed {
    logic                 valid;
    logic [TASK_ID_W-1:0] id;
    logic                 cls;
  } entry_t;

  // Passed from each cell to its right-hand neighbour.
  typedef struct packed {
    logic                 seen_high;
    logic                 hit;
    logic [TASK_ID_W-1:0] id_acc;
  } chain_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                 find;
    logic                 shift;
    logic                 pick;
    logic                 remove_en;
    logic                 fallback;
    logic [TASK_ID_W-1:0] task_id;
    logic                 app_en;
    logic [TASK_ID_W-1:0] app_pos;
    logic [TASK_ID_W-1:0] app_id;
    logic                 app_cls;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/two_class_ready_queue_core.sv]
// Top level of the two-class ready queue: sequencer and the row of cells.
// Depends on trq_pkg and trq_cell.
//
//   channel   ports                 handshake
//   request   req (req_t)           taken when start is high and busy is low
//   result    result (res_t)        valid for the one cycle that done is high
//
// Each item passes through the accept edge, a search pass along the
// cell row (match, oldest high task, removal mark), and a shift pass in which
// the row closes the gap and the appended task is written at the tail. done
// rises in the cycle after the shift, and start is taken in that same cycle.
// Reset is synchronous and empties the row at once. The receiver cannot
// stall; done is high for one cycle only.
`default_nettype none

module two_class_ready_queue_core #(
  parameter int NUM_TASKS = trq_pkg::NUM_TASKS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire trq_pkg::req_t req,
  output logic               done,
  output trq_pkg::res_t      result
);
  import trq_pkg::*;

  // Task ids are six bits wide, so no more than MAX_CELLS tasks can queue.
  localparam int NumCells = (NUM_TASKS < MAX_CELLS) ? NUM_TASKS : MAX_CELLS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIND  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]           state;
  req_t                 req_r;
  res_t                 res_r;
  logic [CNT_W-1:0]     count;
  logic                 app_en;
  logic [TASK_ID_W-1:0] app_pos;
  logic                 app_cls;

  cmd_t                 cmd;
  chain_t               links [NumCells+1];
  entry_t               entries [NumCells];

  logic                 is_pick;
  logic                 any_high;
  logic                 id_in_range;
  logic                 new_cls;
  res_t                 res_next;
  logic [CNT_W-1:0]     count_next;
  logic                 app_en_next;
  logic [TASK_ID_W-1:0] app_pos_next;

  assign busy        = (state != S_IDLE);
  assign is_pick     = (req_r.mode == MODE_PICK);
  assign any_high    = links[NumCells].seen_high;
  assign id_in_range = (32'(req_r.task_id) < NUM_TASKS);
  assign new_cls     = (req_r.priority_req == LOW_PRIORITY_VALUE) ? CLS_LOW : CLS_HIGH;
  assign links[0]    = '0;

  always_comb begin
    cmd.find      = (state == S_FIND);
    cmd.shift     = (state == S_SHIFT);
    cmd.pick      = is_pick;
    cmd.remove_en = is_pick || (req_r.mode == MODE_REPRIO);
    // With no high task queued, pick takes the head cell, so the whole row moves.
    cmd.fallback  = is_pick & ~any_high;
    cmd.task_id   = req_r.task_id;
    cmd.app_en    = app_en;
    cmd.app_pos   = app_pos;
    cmd.app_id    = req_r.task_id;
    cmd.app_cls   = app_cls;
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    entry_t right;
    if (i == NumCells - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = entries[i+1];
    end
    trq_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .chain_in  (links[i]),
      .chain_out (links[i+1]),
      .right_in  (right),
      .entry     (entries[i])
    );
  end

  always_comb begin
    res_next     = '0;
    count_next   = count;
    app_en_next  = 1'b0;
    app_pos_next = count[TASK_ID_W-1:0];
    case (req_r.mode)
      MODE_AWAKEN: begin
        if (links[NumCells].hit) begin
          res_next.status = ST_ALREADY_QUEUED;
        end else if (id_in_range) begin
          app_en_next = 1'b1;
          count_next  = count + CNT_W'(1);
        end
      end
      MODE_PICK: begin
        if (count != '0) begin
          res_next.picked_valid = 1'b1;
          res_next.picked_id    = any_high ? links[NumCells].id_acc : entries[0].id;
          count_next            = count - CNT_W'(1);
        end
      end
      MODE_REPRIO: begin
        if (links[NumCells].hit) begin
          // After the gap closes the tail slot is the last occupied one.
          app_en_next  = 1'b1;
          app_pos_next = TASK_ID_W'(count - CNT_W'(1));
        end else begin
          res_next.status = ST_NOT_QUEUED;
        end
      end
      default: begin
      end
    endcase
    res_next.any_ready = (count_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      app_en <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_FIND;
          end
        end
        S_FIND: begin
          count  <= count_next;
          app_en <= app_en_next;
          state  <= S_SHIFT;
        end
        S_SHIFT: begin
          app_en <= 1'b0;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_r <= req;
    end
    if (state == S_FIND) begin
      res_r   <= res_next;
      app_pos <= app_pos_next;
      app_cls <= new_cls;
    end
  end

  assign result = res_r;

endmodule

`default_nettype wire

[rtl/trq_cell.sv]
// One cell of the ready queue row: holds one queued task and its class.
// Depends on trq_pkg for the entry, link and command types.
`default_nettype none

module trq_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire trq_pkg::cmd_t   cmd,
  input  wire trq_pkg::chain_t chain_in,
  output trq_pkg::chain_t      chain_out,
  input  wire trq_pkg::entry_t right_in,
  output trq_pkg::entry_t      entry
);
  import trq_pkg::*;

  logic                 valid;
  logic [TASK_ID_W-1:0] id;
  logic                 cls;
  logic                 rm;
  logic                 target;
  logic                 load_new;

  always_comb begin
    if (cmd.pick) begin
      // The oldest task of the high class is the one with no high task to its left.
      target = valid & (cls == CLS_HIGH) & ~chain_in.seen_high;
    end else begin
      target = valid & (id == cmd.task_id);
    end
    chain_out.seen_high = chain_in.seen_high | (valid & (cls == CLS_HIGH));
    chain_out.hit       = chain_in.hit | target;
    chain_out.id_acc    = chain_in.id_acc | (target ? id : '0);
  end

  assign load_new = cmd.app_en && (cmd.app_pos == TASK_ID_W'(CELL_IDX));
  assign entry    = '{valid: valid, id: id, cls: cls};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rm    <= 1'b0;
    end else if (cmd.find) begin
      // Every cell at or right of the removed one takes its neighbour's item.
      rm <= cmd.remove_en & (chain_out.hit | cmd.fallback);
    end else if (cmd.shift) begin
      if (load_new) begin
        valid <= 1'b1;
      end else if (rm) begin
        valid <= right_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      if (load_new) begin
        id  <= cmd.app_id;
        cls <= cmd.app_cls;
      end else if (rm) begin
        id  <= right_in.id;
        cls <= right_in.cls;
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb_two_class_ready_queue_core.sv]
// Self-checking testbench for two_class_ready_queue_core: awaken, pick,
// reprioritise and query items checked against a behavioural queue model.
// Depends on trq_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_two_class_ready_queue_core;
  import trq_pkg::*;

  localparam int TASKS      = 64;
  localparam int STALL_MAX  = 1000;
  localparam int TAIL_WAIT  = 8;
  localparam int REQ_W      = $bits(req_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  res_t result;

  two_class_ready_queue_core #(.NUM_TASKS(TASKS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result)
  );

  always #2 clk = ~clk;

  // Behavioural copy of the ready queue: one FIFO of task ids per class.
  logic [TASK_ID_W-1:0] high_line[$];
  logic [TASK_ID_W-1:0] low_line[$];
  bit                   is_queued[TASKS];
  res_t                 pending_results[$];

  int mismatches   = 0;
  int stall_cycles = 0;
  int burst_left   = 0;
  bit pacing_on    = 1'b0;

  function automatic void drop_from_class(logic [TASK_ID_W-1:0] id);
    for (int i = 0; i < high_line.size(); i++) begin
      if (high_line[i] == id) begin
        high_line.delete(i);
        return;
      end
    end
    for (int i = 0; i < low_line.size(); i++) begin
      if (low_line[i] == id) begin
        low_line.delete(i);
        return;
      end
    end
  endfunction

  function automatic void append_ready(logic [TASK_ID_W-1:0] id, logic to_low);
    if (to_low) low_line = {low_line, id};
    else high_line = {high_line, id};
    is_queued[id] = 1'b1;
  endfunction

  function automatic res_t predict_ready_queue(req_t r);
    res_t res;
    logic to_low;
    res = '0;
    to_low = (r.priority_req == LOW_PRIORITY_VALUE);
    case (r.mode)
      MODE_AWAKEN: begin
        if (is_queued[r.task_id]) res.status = ST_ALREADY_QUEUED;
        else append_ready(r.task_id, to_low);
      end
      MODE_PICK: begin
        // The high class always wins; the low class is served only when the high class is empty.
        if (high_line.size() != 0) begin
          res.picked_valid = 1'b1;
          res.picked_id = high_line[0];
          high_line.delete(0);
          is_queued[res.picked_id] = 1'b0;
        end else if (low_line.size() != 0) begin
          res.picked_valid = 1'b1;
          res.picked_id = low_line[0];
          low_line.delete(0);
          is_queued[res.picked_id] = 1'b0;
        end
      end
      MODE_REPRIO: begin
        if (is_queued[r.task_id]) begin
          drop_from_class(r.task_id);
          append_ready(r.task_id, to_low);
        end else begin
          res.status = ST_NOT_QUEUED;
        end
      end
      MODE_QUERY: ;
      default: ;
    endcase
    res.any_ready = (high_line.size() + low_line.size()) != 0;
    return res;
  endfunction

  function automatic req_t make_req(logic [1:0] mode, int id, int prio);
    req_t r;
    r.mode = mode;
    r.task_id = id[TASK_ID_W-1:0];
    r.priority_req = prio[PRIO_W-1:0];
    return r;
  endfunction

  function automatic int random_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'(LOW_PRIORITY_VALUE);
      4: return 0;
      5: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int some_queued_id();
    int n = high_line.size() + low_line.size();
    int k;
    if (n == 0) return $urandom_range(0, TASKS - 1);
    k = $urandom_range(0, n - 1);
    if (k < high_line.size()) return int'(high_line[k]);
    return int'(low_line[k - high_line.size()]);
  endfunction

  function automatic int some_idle_id();
    int id = $urandom_range(0, TASKS - 1);
    for (int tries = 0; tries < 8 && is_queued[id]; tries++) id = $urandom_range(0, TASKS - 1);
    return id;
  endfunction

  // Bursts of random length separated by random gaps, when pacing is enabled.
  task automatic pace();
    int gap;
    if (!pacing_on) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input req_t r);
    res_t expected;
    pace();
    @(negedge clk);
    start = 1'b1;
    req = r;
    do @(posedge clk); while (busy);
    expected = predict_ready_queue(r);
    pending_results = {pending_results, expected};
  endtask

  task automatic wait_until_settled();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item outstanding: expected none, actual %p", $time, result);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("picked_valid", 8'(want.picked_valid), 8'(result.picked_valid));
        check_field("picked_id", 8'(want.picked_id), 8'(result.picked_id));
        check_field("any_ready", 8'(want.any_ready), 8'(result.any_ready));
        check_field("status", 8'(want.status), 8'(result.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(make_req(MODE_QUERY, 63, 255));
    send_item(make_req(MODE_PICK, 0, 0));
    send_item(make_req(MODE_REPRIO, 17, 3));
    send_item(make_req(MODE_AWAKEN, 63, 1));
    send_item(make_req(MODE_AWAKEN, 0, 0));
    send_item(make_req(MODE_AWAKEN, 0, 1));
    send_item(make_req(MODE_AWAKEN, 5, 255));
    send_item(make_req(MODE_AWAKEN, 42, 2));
    send_item(make_req(MODE_AWAKEN, 21, 1));
    // Same class: the task still goes to the back of its class.
    send_item(make_req(MODE_REPRIO, 63, 1));
    send_item(make_req(MODE_REPRIO, 0, 1));
    send_item(make_req(MODE_REPRIO, 5, 255));
    send_item(make_req(MODE_REPRIO, 21, 128));
    send_item(make_req(MODE_QUERY, 0, 0));
    repeat (6) send_item(make_req(MODE_PICK, 63, 255));
    send_item(make_req(MODE_AWAKEN, 63, 1));
    send_item(make_req(MODE_QUERY, 1, 1));
    send_item(make_req(MODE_PICK, 0, 0));
    wait_until_settled();
  endtask

  task automatic test_fill_and_drain();
    int order[TASKS];
    int j;
    int tmp;
    for (int i = 0; i < TASKS; i++) order[i] = i;
    for (int i = TASKS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_item(make_req(MODE_AWAKEN, order[i], random_priority()));
    repeat (20) send_item(make_req(MODE_REPRIO, some_queued_id(), random_priority()));
    repeat (10) send_item(make_req(MODE_AWAKEN, some_queued_id(), random_priority()));
    repeat (TASKS + 2) send_item(make_req(MODE_PICK, $urandom_range(0, 63), random_priority()));
    wait_until_settled();
  endtask

  task automatic test_random_mix(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_item(make_req(MODE_AWAKEN,
                           ($urandom_range(0, 9) == 0) ? some_queued_id() : some_idle_id(),
                           random_priority()));
      else if (pick < 60)
        send_item(make_req(MODE_PICK, $urandom_range(0, 63), $urandom_range(0, 255)));
      else if (pick < 85)
        send_item(make_req(MODE_REPRIO,
                           ($urandom_range(0, 7) == 0) ? some_idle_id() : some_queued_id(),
                           random_priority()));
      else
        send_item(make_req(MODE_QUERY, $urandom_range(0, 63), $urandom_range(0, 255)));
      if (n % 300 == 299) wait_until_settled();
    end
    wait_until_settled();
  endtask

  task automatic test_noise(input int count);
    for (int n = 0; n < count; n++) send_item(req_t'(REQ_W'($urandom)));
    wait_until_settled();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fill_and_drain();
    pacing_on = 1'b1;
    test_random_mix(850);
    test_noise(300);

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
